### rtl/rtit_pkg.sv
package rtit_pkg;

    // Default stack depth: sentinel plus one end node per prefix length
    localparam int STACK_DEPTH = 34;

    localparam logic [31:0] TOP_ADDR     = 32'hFFFF_FFFF;
    localparam logic [15:0] PRIO_WEAKEST = 16'hFFFF;
    localparam logic [5:0]  MAX_LEN      = 6'd32;

    // Status codes carried on every result word of a route
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_ORDER    = 2'd2;

    typedef struct packed {
        logic [31:0] prefix_address;
        logic [5:0]  prefix_length;
        logic [15:0] route_priority;
        logic [15:0] route_nexthop;
        logic        last_route;
    } route_t;

    typedef struct packed {
        logic [31:0] interval_start;
        logic [15:0] interval_nexthop;
        logic        nexthop_valid;
        logic        table_end;
        logic [1:0]  status;
    } interval_t;

    // One pending end node of the stack
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] nexthop;
        logic [15:0] fallback;
        logic [15:0] priority_val;
    } stack_entry_t;

    // Result word handed from the converter to the output register
    typedef struct packed {
        logic      valid;
        interval_t word;
    } put_t;

endpackage

### rtl/rtit_stack_ram.sv
module rtit_stack_ram #(
    parameter int DEPTH = rtit_pkg::STACK_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  rtit_pkg::stack_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output rtit_pkg::stack_entry_t rd_data
);

    rtit_pkg::stack_entry_t mem [DEPTH];
    rtit_pkg::stack_entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/rtit_ctrl.sv
module rtit_ctrl #(
    parameter int STACK_DEPTH = rtit_pkg::STACK_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rtit_pkg::route_t in_data,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_data,
    input  logic [15:0]      default_nexthop,
    input  logic             put_ready,
    output rtit_pkg::put_t   put
);

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MREAD = 8'b0000_0010,
        S_MCMP  = 8'b0000_0100,
        S_PREAD = 8'b0000_1000,
        S_PUSH  = 8'b0001_0000,
        S_FREAD = 8'b0010_0000,
        S_FCMP  = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Control state
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [15:0]     sent_fb_reg, sent_fb_next;
    logic [15:0]     sent_prio_reg, sent_prio_next;
    logic            hold_flag_reg, hold_flag_next;
    logic            prev_seen_reg, prev_seen_next;
    logic [1:0]      status_reg, status_next;
    logic            any_put_reg, any_put_next;

    // Payload state
    logic [31:0] hold_addr_reg, hold_addr_next;
    logic [15:0] hold_nh_reg, hold_nh_next;
    logic [31:0] prev_addr_reg, prev_addr_next;
    logic [5:0]  prev_len_reg, prev_len_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] end_reg, end_next;
    logic        high_top_reg, high_top_next;
    logic [15:0] prio_reg, prio_next;
    logic [15:0] nh_reg, nh_next;
    logic        last_reg, last_next;

    // Stack memory port
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    rtit_pkg::stack_entry_t wr_data;
    logic                   rd_en;
    rtit_pkg::stack_entry_t rd_data;

    // Top-of-stack view and input decode
    logic [SP_W-1:0] sp_dec;
    logic [AW-1:0]   top_idx;
    logic            sp_gt1;
    logic            sp_full;
    logic [31:0]     top_addr;
    logic [15:0]     top_fb;
    logic [15:0]     top_prio;
    logic [5:0]      len_c;
    logic [31:0]     mask;
    logic [31:0]     in_low;
    logic [31:0]     in_high;
    logic            order_err;
    logic            same_hold;
    logic            eqpop;
    logic            ovf;
    logic            push_now;

    function automatic state_t next_phase(input logic last, input logic [1:0] st,
                                          input logic anyp);
        state_t nxt;
        if (last)
        begin
            nxt = S_FREAD;
        end
        else if (st != rtit_pkg::ST_OK && !anyp)
        begin
            nxt = S_FIN;
        end
        else
        begin
            nxt = S_IDLE;
        end
        return nxt;
    endfunction

    rtit_stack_ram #(
        .DEPTH(STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (top_idx),
        .rd_data (rd_data)
    );

    assign in_stall = (state_reg != S_IDLE);

    // Top entry: the sentinel lives in flops, the rest in memory
    assign sp_dec   = sp_reg - SP_W'(1);
    assign top_idx  = sp_dec[AW-1:0];
    assign sp_gt1   = (sp_reg != SP_W'(1));
    assign sp_full  = (sp_reg == SP_W'(STACK_DEPTH));
    assign top_addr = sp_gt1 ? rd_data.addr : rtit_pkg::TOP_ADDR;
    assign top_fb   = sp_gt1 ? rd_data.fallback : sent_fb_reg;
    assign top_prio = sp_gt1 ? rd_data.priority_val : sent_prio_reg;

    // Clamp the length and form the prefix range
    assign len_c   = (in_data.prefix_length > rtit_pkg::MAX_LEN) ? rtit_pkg::MAX_LEN
                                                                 : in_data.prefix_length;
    assign mask    = {32{1'b1}} << (rtit_pkg::MAX_LEN - len_c);
    assign in_low  = in_data.prefix_address & mask;
    assign in_high = in_low | ~mask;
    assign order_err = prev_seen_reg &&
                       ((in_low < prev_addr_reg) ||
                        (in_low == prev_addr_reg && len_c <= prev_len_reg));

    // Route decision terms
    assign same_hold = hold_flag_reg && (hold_addr_reg == low_reg);
    assign eqpop     = sp_gt1 && (top_addr == low_reg);
    assign ovf       = !high_top_reg && sp_full && !eqpop && (top_addr != end_reg);
    assign push_now  = (state_reg == S_PUSH) && (top_addr != end_reg);

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        sent_fb_next   = sent_fb_reg;
        sent_prio_next = sent_prio_reg;
        hold_flag_next = hold_flag_reg;
        prev_seen_next = prev_seen_reg;
        status_next    = status_reg;
        any_put_next   = any_put_reg;
        hold_addr_next = hold_addr_reg;
        hold_nh_next   = hold_nh_reg;
        prev_addr_next = prev_addr_reg;
        prev_len_next  = prev_len_reg;
        low_next       = low_reg;
        end_next       = end_reg;
        high_top_next  = high_top_reg;
        prio_next      = prio_reg;
        nh_next        = nh_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = top_idx;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        put            = '0;

        // Load the written default into the sentinel before the table starts
        if (cfg_we && !prev_seen_reg)
        begin
            sent_fb_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    low_next      = in_low;
                    end_next      = in_high + 32'd1;
                    high_top_next = (in_high == rtit_pkg::TOP_ADDR);
                    prio_next     = in_data.route_priority;
                    nh_next       = in_data.route_nexthop;
                    last_next     = in_data.last_route;
                    any_put_next  = 1'b0;
                    if (order_err)
                    begin
                        status_next = rtit_pkg::ST_ORDER;
                        state_next  = in_data.last_route ? S_FREAD : S_FIN;
                    end
                    else
                    begin
                        status_next    = rtit_pkg::ST_OK;
                        prev_seen_next = 1'b1;
                        prev_addr_next = in_low;
                        prev_len_next  = len_c;
                        state_next     = S_MREAD;
                    end
                end
            end

            S_MREAD:
            begin
                rd_en      = 1'b1;
                state_next = S_MCMP;
            end

            S_MCMP:
            begin
                if (sp_gt1 && top_addr < low_reg)
                begin
                    // Pop an end node that lies below the new route
                    if (!hold_flag_reg || put_ready)
                    begin
                        put.valid                 = hold_flag_reg;
                        put.word.interval_start   = hold_addr_reg;
                        put.word.interval_nexthop = hold_nh_reg;
                        put.word.nexthop_valid    = 1'b1;
                        put.word.status           = status_reg;
                        any_put_next   = any_put_reg | hold_flag_reg;
                        hold_flag_next = 1'b1;
                        hold_addr_next = top_addr;
                        hold_nh_next   = rd_data.nexthop;
                        sp_next        = sp_dec;
                        state_next     = S_MREAD;
                    end
                end
                else if (top_prio < prio_reg)
                begin
                    // Shadowed by a stronger enclosing route: skip
                    state_next = next_phase(last_reg, status_reg, any_put_reg);
                end
                else if (same_hold || !hold_flag_reg || put_ready)
                begin
                    put.valid                 = hold_flag_reg && !same_hold;
                    put.word.interval_start   = hold_addr_reg;
                    put.word.interval_nexthop = hold_nh_reg;
                    put.word.nexthop_valid    = 1'b1;
                    put.word.status           = ovf ? rtit_pkg::ST_OVERFLOW : status_reg;
                    any_put_next   = any_put_reg | put.valid;
                    hold_flag_next = 1'b1;
                    hold_addr_next = low_reg;
                    hold_nh_next   = nh_reg;
                    if (eqpop)
                    begin
                        sp_next = sp_dec;
                    end
                    if (high_top_reg)
                    begin
                        state_next = next_phase(last_reg, status_reg, any_put_next);
                    end
                    else if (ovf)
                    begin
                        status_next = rtit_pkg::ST_OVERFLOW;
                        state_next  = next_phase(last_reg, rtit_pkg::ST_OVERFLOW,
                                                 any_put_next);
                    end
                    else if (eqpop)
                    begin
                        state_next = S_PREAD;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
            end

            S_PREAD:
            begin
                rd_en      = 1'b1;
                state_next = S_PUSH;
            end

            S_PUSH:
            begin
                if (!push_now)
                begin
                    // End node already there: take over its fallback
                    if (sp_gt1)
                    begin
                        wr_en                = 1'b1;
                        wr_addr              = top_idx;
                        wr_data.addr         = rd_data.addr;
                        wr_data.nexthop      = rd_data.nexthop;
                        wr_data.fallback     = nh_reg;
                        wr_data.priority_val = prio_reg;
                    end
                    else
                    begin
                        sent_fb_next   = nh_reg;
                        sent_prio_next = prio_reg;
                    end
                end
                else
                begin
                    wr_en                = 1'b1;
                    wr_addr              = sp_reg[AW-1:0];
                    wr_data.addr         = end_reg;
                    wr_data.nexthop      = top_fb;
                    wr_data.fallback     = nh_reg;
                    wr_data.priority_val = prio_reg;
                    sp_next              = sp_reg + SP_W'(1);
                end
                state_next = next_phase(last_reg, status_reg, any_put_reg);
            end

            S_FREAD:
            begin
                rd_en      = 1'b1;
                state_next = S_FCMP;
            end

            S_FCMP:
            begin
                if (!hold_flag_reg || put_ready)
                begin
                    put.valid                 = hold_flag_reg;
                    put.word.interval_start   = hold_addr_reg;
                    put.word.interval_nexthop = hold_nh_reg;
                    put.word.nexthop_valid    = 1'b1;
                    put.word.status           = status_reg;
                    any_put_next              = any_put_reg | hold_flag_reg;
                    if (sp_gt1 && top_addr != rtit_pkg::TOP_ADDR)
                    begin
                        // Flush one pending end node
                        hold_flag_next = 1'b1;
                        hold_addr_next = top_addr;
                        hold_nh_next   = rd_data.nexthop;
                        sp_next        = sp_dec;
                        state_next     = S_FREAD;
                    end
                    else
                    begin
                        // Close the table and restart
                        put.word.table_end = 1'b1;
                        sp_next        = SP_W'(1);
                        sent_fb_next   = default_nexthop;
                        sent_prio_next = rtit_pkg::PRIO_WEAKEST;
                        hold_flag_next = 1'b0;
                        prev_seen_next = 1'b0;
                        state_next     = (status_reg != rtit_pkg::ST_OK && !any_put_next)
                                         ? S_FIN : S_IDLE;
                    end
                end
            end

            S_FIN:
            begin
                // Status-only word when a failed route produced nothing
                if (put_ready)
                begin
                    put.valid       = 1'b1;
                    put.word.status = status_reg;
                    any_put_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= SP_W'(1);
            sent_fb_reg   <= '0;
            sent_prio_reg <= rtit_pkg::PRIO_WEAKEST;
            hold_flag_reg <= 1'b0;
            prev_seen_reg <= 1'b0;
            status_reg    <= rtit_pkg::ST_OK;
            any_put_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            sent_fb_reg   <= sent_fb_next;
            sent_prio_reg <= sent_prio_next;
            hold_flag_reg <= hold_flag_next;
            prev_seen_reg <= prev_seen_next;
            status_reg    <= status_next;
            any_put_reg   <= any_put_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hold_addr_reg <= hold_addr_next;
        hold_nh_reg   <= hold_nh_next;
        prev_addr_reg <= prev_addr_next;
        prev_len_reg  <= prev_len_next;
        low_reg       <= low_next;
        end_reg       <= end_next;
        high_top_reg  <= high_top_next;
        prio_reg      <= prio_next;
        nh_reg        <= nh_next;
        last_reg      <= last_next;
    end

    // Stack pointer stays between the sentinel and the full depth
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg >= SP_W'(1) && sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer out of range");

    // A word is only handed over when the output register can take it
    a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
        put.valid |-> put_ready)
        else $error("result word dropped");

    // The closing word of a table leaves an empty stack and hold
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        put.valid && put.word.table_end |=> sp_reg == SP_W'(1) && !hold_flag_reg)
        else $error("table not restarted after its last word");

    // No push onto a full stack
    a_no_overflow_push: assert property (@(posedge clk) disable iff (!rst_n)
        push_now |-> !sp_full)
        else $error("push onto full stack");

    // A word without next hop only reports an error
    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        put.valid && !put.word.nexthop_valid |-> put.word.status != rtit_pkg::ST_OK)
        else $error("status-only word without error");

endmodule

### rtl/route_to_interval_table_top.sv
// Route to interval table converter.
// Routes enter on in_valid/in_stall/in_data, sorted by prefix base address and
// then by prefix length; the word with last_route set closes the table.
// Intervals (start address, next hop) leave on out_valid/out_stall/out_data,
// each word carrying the status of the route that produced it.
// The default next hop is written through cfg_valid/cfg_ready/cfg_data; it
// reaches the table at once before the first route, else at the next restart.
// Pending interval ends sit on a stack held in a one-port-read memory, so each
// stack entry looked at takes a read state and then a compare state.
// One route is worked on at a time; the output register lets the block go on
// with a route while the previous word waits to be taken.
// When out_stall is high the converter pauses at its next word until the
// output register frees up; nothing is lost.
// Reset empties the stack down to the sentinel, clears the hold and order
// check, and sets the default next hop to zero. No clearing pass is needed.
module route_to_interval_table_top #(
    parameter int STACK_DEPTH = rtit_pkg::STACK_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rtit_pkg::route_t    in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rtit_pkg::interval_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);

    logic [15:0]         default_nexthop_reg;
    logic                cfg_we;
    logic                put_ready;
    rtit_pkg::put_t      put;
    logic                out_valid_reg;
    rtit_pkg::interval_t out_data_reg;

    // Config register, always writable
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_nexthop_reg <= '0;
        end
        else if (cfg_we)
        begin
            default_nexthop_reg <= cfg_data;
        end
    end

    rtit_ctrl #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .default_nexthop (default_nexthop_reg),
        .put_ready       (put_ready),
        .put             (put)
    );

    // Output register: load a new word, drop it once taken
    assign put_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (put.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (put.valid)
        begin
            out_data_reg <= put.word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### bench/interval_table_checker.sv
module interval_table_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  rtit_pkg::route_t    in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  rtit_pkg::interval_t out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    output int                  errors,
    output int                  pending
);

    localparam int          MAX_WORDS = 40;
    localparam logic [16:0] NH_NONE   = 17'h1_0000;

    // End node stack, bottom entry is the all-ones sentinel
    logic [31:0] end_addr [rtit_pkg::STACK_DEPTH];
    logic [16:0] end_nh   [rtit_pkg::STACK_DEPTH];
    logic [15:0] end_fb   [rtit_pkg::STACK_DEPTH];
    logic [15:0] end_prio [rtit_pkg::STACK_DEPTH];
    int unsigned depth;

    // One-entry hold for an interval that a later one may replace
    bit          hold_valid;
    logic [31:0] hold_start;
    logic [16:0] hold_nh;

    // Order check against the last accepted route of the table
    bit          table_open;
    logic [31:0] last_low;
    logic [5:0]  last_len;

    logic [15:0] dflt_nh;

    rtit_pkg::interval_t route_words[$];
    rtit_pkg::interval_t expected_intervals[$];
    int                  mismatch_count = 0;
    int                  expected_count = 0;

    assign errors  = mismatch_count;
    assign pending = expected_count;

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("%0t interval_table_checker: %s", $realtime, what);
    endtask

    function automatic void restart_table();
        end_addr[0] = rtit_pkg::TOP_ADDR;
        end_nh[0]   = NH_NONE;
        end_fb[0]   = dflt_nh;
        end_prio[0] = rtit_pkg::PRIO_WEAKEST;
        depth       = 1;
        hold_valid  = 1'b0;
        hold_start  = '0;
        hold_nh     = '0;
        table_open  = 1'b0;
        last_low    = '0;
        last_len    = '0;
    endfunction

    function automatic void queue_word(logic [31:0] start, logic [16:0] nh, bit closing);
        rtit_pkg::interval_t w;
        if (route_words.size() >= MAX_WORDS)
            return;
        w.interval_start   = start;
        w.interval_nexthop = nh[16] ? 16'h0 : nh[15:0];
        w.nexthop_valid    = !nh[16];
        w.table_end        = closing;
        w.status           = rtit_pkg::ST_OK;
        route_words.push_back(w);
    endfunction

    // Replace the held interval when a route starts at the same address,
    // else release the held one and hold the new one
    function automatic void place_interval(logic [31:0] start, logic [16:0] nh,
                                          bit from_route);
        if (from_route && hold_valid && hold_start == start)
        begin
            hold_nh = nh;
            return;
        end
        if (hold_valid)
            queue_word(hold_start, hold_nh, 1'b0);
        hold_valid = 1'b1;
        hold_start = start;
        hold_nh    = nh;
    endfunction

    function automatic void pop_end_node();
        place_interval(end_addr[depth-1], end_nh[depth-1], 1'b0);
        depth--;
    endfunction

    function automatic void load_default(logic [15:0] v);
        dflt_nh = v;
        if (!table_open)
            end_fb[0] = v;
    endfunction

    function automatic void predict_route(rtit_pkg::route_t r);
        logic [5:0]  len;
        logic [31:0] mask;
        logic [31:0] low;
        logic [31:0] high;
        logic [31:0] next_start;
        logic [1:0]  st;
        int unsigned top;
        route_words.delete();
        st   = rtit_pkg::ST_OK;
        len  = (r.prefix_length > rtit_pkg::MAX_LEN) ? rtit_pkg::MAX_LEN : r.prefix_length;
        mask = (len == 0) ? 32'h0 : (rtit_pkg::TOP_ADDR << (rtit_pkg::MAX_LEN - len));
        low  = r.prefix_address & mask;
        high = low | ~mask;

        if (table_open && (low < last_low || (low == last_low && len <= last_len)))
        begin
            st = rtit_pkg::ST_ORDER;
        end
        else
        begin
            table_open = 1'b1;
            last_low   = low;
            last_len   = len;
            // Pop every end node below this route's start
            while (depth > 1 && end_addr[depth-1] < low)
                pop_end_node();
            top = depth - 1;
            // Skip a route shadowed by a stronger enclosing one
            if (!(end_prio[top] < r.route_priority))
            begin
                place_interval(low, {1'b0, r.route_nexthop}, 1'b1);
                if (depth > 1 && end_addr[top] == low)
                    depth--;
                if (high != rtit_pkg::TOP_ADDR)
                begin
                    next_start = high + 32'd1;
                    top = depth - 1;
                    if (end_addr[top] == next_start)
                    begin
                        end_fb[top]   = r.route_nexthop;
                        end_prio[top] = r.route_priority;
                    end
                    else if (depth < rtit_pkg::STACK_DEPTH)
                    begin
                        end_addr[depth] = next_start;
                        end_nh[depth]   = {1'b0, end_fb[top]};
                        end_fb[depth]   = r.route_nexthop;
                        end_prio[depth] = r.route_priority;
                        depth++;
                    end
                    else
                    begin
                        st = rtit_pkg::ST_OVERFLOW;
                    end
                end
            end
        end

        // Flush the stack down to the sentinel and close the table
        if (r.last_route)
        begin
            while (depth > 1 && end_addr[depth-1] < rtit_pkg::TOP_ADDR)
                pop_end_node();
            if (hold_valid)
                queue_word(hold_start, hold_nh, 1'b1);
            restart_table();
        end

        if (st != rtit_pkg::ST_OK && route_words.size() == 0)
            queue_word(32'h0, NH_NONE, 1'b0);
        foreach (route_words[k])
        begin
            route_words[k].status = st;
            expected_intervals.push_back(route_words[k]);
        end
    endfunction

    task automatic check_interval(rtit_pkg::interval_t got);
        rtit_pkg::interval_t want;
        if (expected_intervals.size() == 0)
        begin
            report_mismatch($sformatf("word %h with nothing expected", got));
            return;
        end
        want = expected_intervals.pop_front();
        if (got.interval_start !== want.interval_start)
            report_mismatch($sformatf("interval_start %h, want %h",
                                      got.interval_start, want.interval_start));
        if (got.interval_nexthop !== want.interval_nexthop)
            report_mismatch($sformatf("interval_nexthop %h, want %h",
                                      got.interval_nexthop, want.interval_nexthop));
        if (got.nexthop_valid !== want.nexthop_valid)
            report_mismatch($sformatf("nexthop_valid %b, want %b",
                                      got.nexthop_valid, want.nexthop_valid));
        if (got.table_end !== want.table_end)
            report_mismatch($sformatf("table_end %b, want %b",
                                      got.table_end, want.table_end));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    endtask

    // Track each channel at the edge its word is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_nh = '0;
            restart_table();
            expected_intervals.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                load_default(cfg_data);
            if (in_valid && !in_stall)
                predict_route(in_data);
            if (out_valid && !out_stall)
                check_interval(out_data);
        end
        expected_count = expected_intervals.size();
    end

endmodule

### bench/tb_top.sv
module tb_top;

    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ROUTES   = 60;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    rtit_pkg::route_t    in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    rtit_pkg::interval_t out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [15:0]         cfg_data  = '0;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;
    int routes_sent  = 0;
    int mismatches;
    int outstanding;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    route_to_interval_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    interval_table_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (mismatches),
        .pending   (outstanding)
    );

    // Stall the result side at random
    always @(negedge clk)
        out_stall <= (int'($urandom_range(0, 99)) < stall_pct);

    // End the run when no word moves on any channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic rtit_pkg::route_t make_route(logic [31:0] addr, logic [5:0] len,
                                                    logic [15:0] prio, logic [15:0] nh,
                                                    logic last);
        rtit_pkg::route_t r;
        r.prefix_address = addr;
        r.prefix_length  = len;
        r.route_priority = prio;
        r.route_nexthop  = nh;
        r.last_route     = last;
        return r;
    endfunction

    // Sort key: masked base address, then effective length
    function automatic logic [37:0] route_key(rtit_pkg::route_t r);
        logic [5:0]  len;
        logic [31:0] mask;
        len  = (r.prefix_length > rtit_pkg::MAX_LEN) ? rtit_pkg::MAX_LEN : r.prefix_length;
        mask = (len == 0) ? 32'h0 : (rtit_pkg::TOP_ADDR << (rtit_pkg::MAX_LEN - len));
        return {r.prefix_address & mask, len};
    endfunction

    // Offer one route word and hold it until taken
    task automatic send_route(rtit_pkg::route_t r);
        while (int'($urandom_range(0, 99)) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        routes_sent++;
    endtask

    // Drop valid, wait for every expected interval, then let the block settle
    task automatic wait_results(int settle);
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (settle)
            @(negedge clk);
    endtask

    task automatic write_default_nexthop(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Build one table around a random base so prefixes nest, sort it, and
    // leave a few duplicates and at most one swap in as broken order
    task automatic send_random_table();
        rtit_pkg::route_t tbl[$];
        rtit_pkg::route_t r;
        rtit_pkg::route_t t;
        logic [31:0]      base;
        int               n;
        int               j;
        int               pick;
        base = $urandom;
        if ($urandom_range(0, 9) == 0)
            base[31:8] = 24'hFF_FFFF;
        n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(12, 30))
                                        : int'($urandom_range(1, 10));
        repeat (n)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 10)
                r.prefix_address = $urandom;
            else
                r.prefix_address = base ^ ($urandom >> $urandom_range(0, 31));
            pick = int'($urandom_range(0, 99));
            if (pick < 4)
                r.prefix_length = 6'($urandom_range(33, 63));
            else if (pick < 10)
                r.prefix_length = 6'd0;
            else
                r.prefix_length = 6'($urandom_range(1, 32));
            if ($urandom_range(0, 99) < 70)
                r.route_priority = 16'($urandom_range(0, 7));
            else
                r.route_priority = 16'($urandom_range(0, 65535));
            r.route_nexthop = 16'($urandom_range(0, 65535));
            r.last_route    = 1'b0;
            j = tbl.size();
            tbl.push_back(r);
            while (j > 0 && route_key(tbl[j-1]) > route_key(r))
            begin
                tbl[j] = tbl[j-1];
                j--;
            end
            tbl[j] = r;
        end
        for (j = tbl.size() - 1; j > 0; j--)
        begin
            if (route_key(tbl[j]) == route_key(tbl[j-1]) && $urandom_range(0, 9) != 0)
                tbl.delete(j);
        end
        if (tbl.size() > 1 && $urandom_range(0, 9) == 0)
        begin
            j = int'($urandom_range(0, tbl.size() - 2));
            t = tbl[j];
            tbl[j] = tbl[j+1];
            tbl[j+1] = t;
        end
        if (tbl.size() > 2 && $urandom_range(0, 19) == 0)
        begin
            j = int'($urandom_range(0, tbl.size() - 2));
            tbl[j].last_route = 1'b1;
        end
        tbl[tbl.size()-1].last_route = 1'b1;
        foreach (tbl[k])
            send_route(tbl[k]);
    endtask

    initial
    begin
        int len;
        int phase;
        int first;
        bit paused;
        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_default_nexthop(16'hFFFF);

        // Default route, nested route, then a late register write that
        // only lands at the next restart
        send_route(make_route(32'h0000_0000, 6'd0, 16'd100, 16'd1, 1'b0));
        send_route(make_route(32'h0A00_0000, 6'd8, 16'd50, 16'd2, 1'b0));
        wait_results(SETTLE_CYCLES);
        write_default_nexthop(16'h1234);
        // Shadowed route, duplicate after masking, over-long length,
        // out of order route carrying the last mark
        send_route(make_route(32'h0A01_0000, 6'd16, 16'hFFFF, 16'd3, 1'b0));
        send_route(make_route(32'h0A01_00FF, 6'd16, 16'd7, 16'd5, 1'b0));
        send_route(make_route(32'h0A02_0304, 6'd63, 16'd10, 16'd4, 1'b0));
        send_route(make_route(32'h0900_0000, 6'd8, 16'd0, 16'd6, 1'b1));

        // Deep nest on one address, then a route at the top address
        for (len = 1; len < 32; len += 2)
            send_route(make_route(32'hA5A5_A5A5, len[5:0], 16'(1000 - len),
                                  16'(len), 1'b0));
        send_route(make_route(32'hA5A5_A5A5, 6'd32, 16'd0, 16'h0000, 1'b0));
        send_route(make_route(rtit_pkg::TOP_ADDR, 6'd32, 16'd0, 16'hFFFF, 1'b1));

        // Random tables under each idling pattern
        for (phase = 0; phase < 4; phase++)
        begin
            wait_results(SETTLE_CYCLES);
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    write_default_nexthop(16'h0000);
                end
                1:
                begin
                    idle_pct  = 50;
                    stall_pct = 0;
                    write_default_nexthop(16'($urandom));
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 50;
                    write_default_nexthop(16'h8001);
                end
                default:
                begin
                    idle_pct  = 21;
                    stall_pct = 21;
                    write_default_nexthop(16'hFFFF);
                end
            endcase
            first  = routes_sent;
            paused = 1'b0;
            while (routes_sent - first < PHASE_ROUTES)
            begin
                send_random_table();
                // Hold off the sender once until the result side runs dry
                if (phase == 2 && !paused && routes_sent - first > PHASE_ROUTES / 2)
                begin
                    wait_results(0);
                    paused = 1'b1;
                end
            end
        end

        wait_results(SETTLE_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
